// ===== design/adlc_pkg.sv =====
package adlc_pkg;

   localparam logic [7:0] NL_BYTE   = 8'h0A;
   localparam logic [7:0] CR_BYTE   = 8'h0D;
   localparam logic [7:0] ZERO_BYTE = 8'h00;
   localparam logic [7:0] LEN_MAX   = 8'd255;

   localparam int QUEUE_DEPTH = 4;

   // One classified beat handed from the front part to the back part.
   typedef struct packed {
      logic       mismatch;          // this byte differs from the stored line
      logic       line_end;          // a line finishes with this beat
      logic [7:0] line_length;       // clipped length of the finished line
      logic       prev_stored;       // a line was stored before this one finished
      logic       length_match;      // finished length equals stored length
      logic       done;              // end of stream
      logic       done_prev_stored;  // a line is stored when the stream ends
   } entry_type;

endpackage

// ===== design/adlc_front.sv =====
module adlc_front
   import adlc_pkg::*;
#(
   parameter int MAX_LINE = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_input,
   output logic       push_valid,
   output entry_type  push_entry,
   input  logic       queue_full
);

   localparam int PW = (MAX_LINE > 2) ? $clog2(MAX_LINE) : 1;
   localparam logic [PW-1:0] LAST_POS = PW'(MAX_LINE - 1);

   typedef struct packed {
      logic [7:0] data;
      logic       compare;
      logic       force_mm;
      entry_type  entry;
   } stage_type;

   logic [7:0] line_mem_ff [MAX_LINE];
   logic [7:0] rd_data_ff;

   logic          s1_valid_ff, s1_valid_in;
   stage_type     s1_ff, s1_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] eff_ff, eff_in;
   logic          zero_ff, zero_in;
   logic          have_prev_ff, have_prev_in;
   logic [PW-1:0] prev_len_ff, prev_len_in;
   logic          mem_write;
   logic          accept;

   assign req_stall = s1_valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;
   assign push_valid = s1_valid_ff && !queue_full;

   always_comb begin
      push_entry = s1_ff.entry;
      push_entry.mismatch = s1_ff.compare && (s1_ff.force_mm || (rd_data_ff != s1_ff.data));
   end

   always_comb begin
      logic [PW-1:0] p_n;
      logic [PW-1:0] e_n;
      logic          z_n;
      logic          fin;
      logic [PW-1:0] fin_len;
      logic          gen;

      pos_in       = pos_ff;
      eff_in       = eff_ff;
      zero_in      = zero_ff;
      have_prev_in = have_prev_ff;
      prev_len_in  = prev_len_ff;
      mem_write    = 1'b0;
      s1_in        = s1_ff;
      gen          = 1'b0;
      fin          = 1'b0;
      p_n          = pos_ff;
      e_n          = eff_ff;
      z_n          = zero_ff;

      s1_in.data           = req_data_byte;
      s1_in.compare        = 1'b0;
      s1_in.force_mm       = 1'b0;
      s1_in.entry.mismatch = 1'b0;
      s1_in.entry.done     = 1'b0;

      if (req_end_of_input) begin
         gen = 1'b1;
         fin = (pos_ff != '0);
         s1_in.entry.done = 1'b1;
      end else if (req_data_byte == CR_BYTE) begin
         gen = 1'b0;
      end else if (req_data_byte == NL_BYTE) begin
         gen = 1'b1;
         fin = 1'b1;
      end else begin
         gen = 1'b1;
         if (!zero_ff) begin
            if (req_data_byte == ZERO_BYTE) begin
               z_n = 1'b1;
               e_n = pos_ff;
            end else begin
               s1_in.compare  = 1'b1;
               s1_in.force_mm = !have_prev_ff || (pos_ff >= prev_len_ff);
               mem_write      = accept;
            end
         end
         p_n = pos_ff + PW'(1);
         fin = (p_n == LAST_POS);
      end

      fin_len = z_n ? e_n : p_n;
      s1_in.entry.line_end         = fin;
      s1_in.entry.line_length      = (16'(fin_len) > 16'(LEN_MAX)) ? LEN_MAX : 8'(fin_len);
      s1_in.entry.prev_stored      = have_prev_ff;
      s1_in.entry.length_match     = (fin_len == prev_len_ff);
      s1_in.entry.done_prev_stored = have_prev_ff || fin;

      if (accept) begin
         if (req_end_of_input) begin
            pos_in       = '0;
            eff_in       = '0;
            zero_in      = 1'b0;
            have_prev_in = 1'b0;
            prev_len_in  = '0;
         end else if (fin) begin
            pos_in       = '0;
            eff_in       = '0;
            zero_in      = 1'b0;
            have_prev_in = 1'b1;
            prev_len_in  = fin_len;
         end else begin
            pos_in  = p_n;
            eff_in  = e_n;
            zero_in = z_n;
         end
      end

      if (accept) begin
         s1_valid_in = gen;
      end else if (push_valid) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= line_mem_ff[pos_ff];
         s1_ff      <= s1_in;
      end
      if (mem_write) begin
         line_mem_ff[pos_ff] <= req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         pos_ff       <= '0;
         eff_ff       <= '0;
         zero_ff      <= 1'b0;
         have_prev_ff <= 1'b0;
         prev_len_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         pos_ff       <= pos_in;
         eff_ff       <= eff_in;
         zero_ff      <= zero_in;
         have_prev_ff <= have_prev_in;
         prev_len_ff  <= prev_len_in;
      end
   end

endmodule

// ===== design/adlc_queue.sv =====
module adlc_queue
   import adlc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  entry_type push_entry,
   output logic      queue_full,
   output logic      head_valid,
   output entry_type head_entry,
   input  logic      pop
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   entry_type     slot_ff [QUEUE_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_pop;

   assign queue_full = (count_ff == CW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !push_valid) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/adlc_back.sv =====
module adlc_back
   import adlc_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  entry_type   head_entry,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_line_kept,
   output logic [31:0] rsp_closed_count,
   output logic [7:0]  rsp_line_length,
   output logic        rsp_stream_done
);

   logic                   mm_ff, mm_in;
   logic [COUNT_WIDTH-1:0] group_ff, group_in;
   logic                   done_phase_ff, done_phase_in;
   logic                   valid_ff, valid_in;
   logic                   kept_ff, kept_in;
   logic [31:0]            closed_ff, closed_in;
   logic [7:0]             len_ff, len_in;
   logic                   sdone_ff, sdone_in;
   logic                   out_free;
   logic                   acc;
   logic                   same;
   logic [31:0]            group_clip;

   assign rsp_valid        = valid_ff;
   assign rsp_line_kept    = kept_ff;
   assign rsp_closed_count = closed_ff;
   assign rsp_line_length  = len_ff;
   assign rsp_stream_done  = sdone_ff;

   assign out_free   = !valid_ff || !rsp_stall;
   assign acc        = mm_ff || head_entry.mismatch;
   assign same       = head_entry.prev_stored && !acc && head_entry.length_match;
   assign group_clip = (64'(group_ff) > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                                  : 32'(group_ff);

   always_comb begin
      mm_in         = mm_ff;
      group_in      = group_ff;
      done_phase_in = done_phase_ff;
      pop           = 1'b0;
      valid_in      = out_free ? 1'b0 : valid_ff;
      kept_in       = kept_ff;
      closed_in     = closed_ff;
      len_in        = len_ff;
      sdone_in      = sdone_ff;

      if (head_valid) begin
         if (done_phase_ff || (head_entry.done && !head_entry.line_end)) begin
            if (out_free) begin
               valid_in      = 1'b1;
               kept_in       = 1'b0;
               closed_in     = head_entry.done_prev_stored ? group_clip : 32'd0;
               len_in        = 8'd0;
               sdone_in      = 1'b1;
               pop           = 1'b1;
               group_in      = '0;
               mm_in         = 1'b0;
               done_phase_in = 1'b0;
            end
         end else if (head_entry.line_end) begin
            if (out_free) begin
               valid_in = 1'b1;
               len_in   = head_entry.line_length;
               sdone_in = 1'b0;
               mm_in    = 1'b0;
               if (same) begin
                  kept_in   = 1'b0;
                  closed_in = 32'd0;
                  group_in  = (group_ff != '1) ? group_ff + COUNT_WIDTH'(1) : group_ff;
               end else begin
                  kept_in   = 1'b1;
                  closed_in = head_entry.prev_stored ? group_clip : 32'd0;
                  group_in  = COUNT_WIDTH'(1);
               end
               // hold the beat for its final result when the stream ends here
               if (head_entry.done) begin
                  done_phase_in = 1'b1;
               end else begin
                  pop = 1'b1;
               end
            end
         end else begin
            mm_in = acc;
            pop   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      kept_ff   <= kept_in;
      closed_ff <= closed_in;
      len_ff    <= len_in;
      sdone_ff  <= sdone_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mm_ff         <= 1'b0;
         group_ff      <= '0;
         done_phase_ff <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         mm_ff         <= mm_in;
         group_ff      <= group_in;
         done_phase_ff <= done_phase_in;
         valid_ff      <= valid_in;
      end
   end

endmodule

// ===== design/adjacent_duplicate_line_collapser_top.sv =====
// Path: the beat that finishes its line passes the front stage with line-store read, a queue
//   slot and the result register, in that order.
// Throughput: one beat per cycle unless the queue is full; an end-of-stream beat that closes
//   a partial line yields two results in turn, set by the back part's single result register.
// Reset: synchronous, active high; clears positions, group count and queue pointers.
//   The line store is not cleared; only entries written in the current stream are compared.
module adjacent_duplicate_line_collapser_top
   import adlc_pkg::*;
#(
   parameter int MAX_LINE    = 256,
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_line_kept,
   output logic [31:0] rsp_closed_count,
   output logic [7:0]  rsp_line_length,
   output logic        rsp_stream_done
);

   // front -> queue
   logic      push_valid;
   entry_type push_entry;
   logic      queue_full;

   // queue -> back
   logic      head_valid;
   entry_type head_entry;
   logic      pop;

   // Classify each beat, track line position, write the line store in place and
   // compare against its old content in the following cycle.
   adlc_front #(
      .MAX_LINE(MAX_LINE)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_end_of_input (req_end_of_input),
      .push_valid       (push_valid),
      .push_entry       (push_entry),
      .queue_full       (queue_full)
   );

   // Decouple the front from a stalled result channel.
   adlc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .queue_full (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   // Accumulate mismatches, decide group boundaries, count repeats, drive results.
   adlc_back #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_entry       (head_entry),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_line_kept    (rsp_line_kept),
      .rsp_closed_count (rsp_closed_count),
      .rsp_line_length  (rsp_line_length),
      .rsp_stream_done  (rsp_stream_done)
   );

endmodule

// ===== design/adlc_checker.sv =====
module adlc_checker #(
   parameter int MAX_LINE = 256
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_data_byte,
   input logic        req_end_of_input,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_line_kept,
   input logic [31:0] rsp_closed_count,
   input logic [7:0]  rsp_line_length,
   input logic        rsp_stream_done
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_line_kept)
         && $stable(rsp_closed_count) && $stable(rsp_line_length) && $stable(rsp_stream_done))
      else $error("result beat changed while stalled");

   a_repeat_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_line_kept && !rsp_stream_done |-> rsp_closed_count == 32'd0)
      else $error("repeated line reports a closed group");

   a_final_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_done |-> !rsp_line_kept && rsp_line_length == 8'd0)
      else $error("final beat carries line data");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_line_length) <= 32'(MAX_LINE - 1))
      else $error("line length beyond line limit");

endmodule

bind adjacent_duplicate_line_collapser_top adlc_checker #(.MAX_LINE(MAX_LINE)) u_adlc_checker (.*);
